FILE: rtl/utf8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned CountWidthDefault = 32;
  localparam int unsigned CodeW = 32;
  localparam int unsigned LenW = 32;
  localparam int unsigned OwedW = 3;

  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] PAYLOAD6 = 8'h3F;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             char_done;
    logic             bad_byte;
    logic             string_end;
    logic [LenW-1:0]  string_length;
  } out_beat_t;

  // sequence state carried from byte to byte (character count kept apart)
  typedef struct packed {
    logic [OwedW-1:0] bytes_owed;
    logic [CodeW-1:0] partial_value;
    logic             seen_error;
  } seq_state_t;

endpackage

FILE: rtl/utf8d_decode.sv
// combinational decode of one byte against the current sequence state
module utf8d_decode #(
  parameter int unsigned COUNT_WIDTH = utf8d_pkg::CountWidthDefault
) (
  input  utf8d_pkg::in_beat_t   beat,
  input  utf8d_pkg::seq_state_t cur,
  input  logic [COUNT_WIDTH-1:0] count,
  output utf8d_pkg::seq_state_t nxt,
  output logic [COUNT_WIDTH-1:0] count_next,
  output utf8d_pkg::out_beat_t  result
);
  import utf8d_pkg::*;

  seq_state_t             st;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [3:0]             lead_ones;
  logic [7:0]             lead_mask;
  logic [7:0]             cont_bits;
  logic [LenW-1:0]        len_sat;

  // start of string clears everything before the byte is looked at
  always_comb begin
    if (beat.first_byte) begin
      st  = '0;
      cnt = '0;
    end else begin
      st  = cur;
      cnt = count;
    end
  end

  assign cnt_inc   = (&cnt) ? cnt : cnt + 1'b1;
  assign cont_bits = beat.byte_in & PAYLOAD6;
  assign lead_mask = 8'hFF >> (lead_ones + 4'd1);

  // leading ones of the byte: set by the highest zero bit, eight when there is none
  always_comb begin
    lead_ones = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (!beat.byte_in[i]) begin
        lead_ones = 4'd7 - 4'(i);
      end
    end
  end

  // report count saturated to the length field
  if (COUNT_WIDTH > LenW) begin : g_wide
    function automatic logic [COUNT_WIDTH-LenW-1:0] cnt_sel_hi(
      input logic [COUNT_WIDTH-1:0] v);
      return v[COUNT_WIDTH-1:LenW];
    endfunction
    assign len_sat = (|cnt_sel_hi(count_next)) ? '1 : count_next[LenW-1:0];
  end else begin : g_narrow
    assign len_sat = LenW'(count_next);
  end

  always_comb begin
    nxt        = st;
    count_next = cnt;
    result     = '0;

    if (st.bytes_owed != '0) begin
      if ((beat.byte_in & CONT_MASK) != CONT_MARK) begin
        result.bad_byte   = 1'b1;
        nxt.seen_error    = 1'b1;
        nxt.bytes_owed    = '0;
        nxt.partial_value = '0;
      end else begin
        nxt.partial_value = {st.partial_value[CodeW-7:0], cont_bits[5:0]};
        nxt.bytes_owed    = st.bytes_owed - 1'b1;
        if (nxt.bytes_owed == '0) begin
          result.code_point = nxt.partial_value;
          result.char_done  = 1'b1;
          count_next        = cnt_inc;
          nxt.partial_value = '0;
        end
      end
    end else begin
      if (lead_ones == 4'd0) begin
        result.code_point = CodeW'(beat.byte_in);
        result.char_done  = 1'b1;
        count_next        = cnt_inc;
      end else if (lead_ones == 4'd1) begin
        result.bad_byte = 1'b1;
        nxt.seen_error  = 1'b1;
      end else begin
        nxt.bytes_owed    = OwedW'(lead_ones - 4'd1);
        nxt.partial_value = CodeW'(beat.byte_in & lead_mask);
      end
    end

    result.string_end = beat.last_byte;
    if (beat.last_byte) begin
      if (!nxt.seen_error && nxt.bytes_owed == '0) begin
        result.string_length = len_sat;
      end
      nxt.bytes_owed    = '0;
      nxt.partial_value = '0;
    end
  end

endmodule

FILE: rtl/utf8_stream_decoder_core.sv
// top level of the utf-8 stream decoder: byte beats in, character beats out
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | into core | in_valid / in_stall     | in_data  (byte, first, last)
//   out     | from core | out_valid / out_stall   | out_data (code point, flags,
//           |           |                         |           string length)
//
// one beat per cycle sustained while out_stall is low; each input beat passes
// through the input register, then is decoded into the result register
// the sequence state and character count update as a byte moves from the
// input register into the result register, so each byte sees its predecessor
// synchronous active-high reset empties both registers and clears the state
// out_stall holds the result register, and the input register then holds too;
// in_stall rises only when the input register is full and cannot move on
module utf8_stream_decoder_core #(
  parameter int unsigned COUNT_WIDTH = utf8d_pkg::CountWidthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  utf8d_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output utf8d_pkg::out_beat_t out_data
);
  import utf8d_pkg::*;

  // input register
  logic     hold_valid;
  in_beat_t hold;

  // sequence state and character count
  seq_state_t             seq;
  seq_state_t             seq_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  out_beat_t              result;

  logic out_free;
  logic advance;

  // result register may take a new beat when empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  utf8d_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .beat      (hold),
    .cur       (seq),
    .count     (count),
    .nxt       (seq_next),
    .count_next(count_next),
    .result    (result)
  );

  // input register: loads whenever it is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold <= in_data;
    end
  end

  // state moves only when a byte is decoded into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq   <= '0;
      count <= '0;
    end else if (advance) begin
      seq   <= seq_next;
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

FILE: tb/utf8_stream_decoder_checker.sv
// result checker for the utf-8 stream decoder: predicts every result beat and compares
module utf8_stream_decoder_checker #(
  parameter int unsigned COUNT_WIDTH = utf8d_pkg::CountWidthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  utf8d_pkg::in_beat_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  utf8d_pkg::out_beat_t out_data,
  output int unsigned          mismatch_count,
  output int unsigned          awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import utf8d_pkg::*;

  // predicted decoder state
  logic [OwedW-1:0]       owed;
  logic [CodeW-1:0]       partial;
  logic [COUNT_WIDTH-1:0] chars;
  logic                   err_seen;

  out_beat_t awaited_beats[$];
  out_beat_t want;

  function automatic int unsigned lead_ones(logic [7:0] b);
    int unsigned n;
    n = 0;
    while (n < 8 && b[7 - n]) n++;
    return n;
  endfunction

  function automatic void bump_chars();
    if (chars != '1) chars = chars + 1'b1;
  endfunction

  function automatic out_beat_t decode_byte(in_beat_t beat);
    out_beat_t   r;
    int unsigned n;
    logic [63:0] wide;
    r = '0;
    if (beat.first_byte) begin
      chars = '0;
      err_seen = 1'b0;
      owed = '0;
      partial = '0;
    end
    if (owed != 0) begin
      if ((beat.byte_in & CONT_MASK) != CONT_MARK) begin
        // bad continuation: byte is swallowed, not re-read as a lead
        r.bad_byte = 1'b1;
        err_seen = 1'b1;
        owed = '0;
        partial = '0;
      end else begin
        partial = {partial[CodeW-7:0], beat.byte_in[5:0]};
        owed = owed - 1'b1;
        if (owed == 0) begin
          r.code_point = partial;
          r.char_done = 1'b1;
          bump_chars();
          partial = '0;
        end
      end
    end else begin
      n = lead_ones(beat.byte_in);
      if (n == 0) begin
        r.code_point = CodeW'(beat.byte_in);
        r.char_done = 1'b1;
        bump_chars();
      end else if (n == 1) begin
        r.bad_byte = 1'b1;
        err_seen = 1'b1;
      end else begin
        owed = OwedW'(n - 1);
        partial = CodeW'(beat.byte_in & (8'hFF >> (n + 1)));
      end
    end
    if (beat.last_byte) begin
      r.string_end = 1'b1;
      if (!err_seen && owed == 0) begin
        wide = 64'(chars);
        r.string_length = (wide > 64'hFFFF_FFFF) ? '1 : wide[LenW-1:0];
      end
      owed = '0;
      partial = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      owed = '0;
      partial = '0;
      chars = '0;
      err_seen = 1'b0;
      mismatch_count = 0;
      awaited_beats.delete();
    end else begin
      if (in_valid && !in_stall) awaited_beats.push_back(decode_byte(in_data));
      if (out_valid && !out_stall) begin
        if (awaited_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with nothing awaited: cp=%h done=%b bad=%b",
                     $realtime, out_data.code_point, out_data.char_done,
                     out_data.bad_byte, " end=%b len=%0d",
                     out_data.string_end, out_data.string_length);
        end else begin
          want = awaited_beats.pop_front();
          if (out_data !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch exp cp=%h done=%b bad=%b end=%b len=%0d",
                       $realtime, want.code_point, want.char_done, want.bad_byte,
                       want.string_end, want.string_length);
              $display("%0t:          got cp=%h done=%b bad=%b end=%b len=%0d",
                       $realtime, out_data.code_point, out_data.char_done,
                       out_data.bad_byte, out_data.string_end, out_data.string_length);
            end
          end
        end
      end
    end
    awaited_count = awaited_beats.size();
  end

endmodule

FILE: tb/utf8_stream_decoder_core_tb.sv
// top of the utf-8 stream decoder testbench: byte stimulus, idling and verdict
module utf8_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import utf8d_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  int unsigned mismatch_count;
  int unsigned awaited_count;

  // calm: no idling for the current string; tail: no idling at all near the end
  logic        calm;
  logic        tail;
  int unsigned beats_sent;

  utf8_stream_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  utf8_stream_decoder_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .awaited_count (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling: the whole run needs well under a tenth of this
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver side: random stall bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && !tail && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one byte beat; returns at the edge that accepted it, valid still high
  task automatic send_beat(logic [7:0] b, logic first, logic last);
    if (!calm && !tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{byte_in: b, first_byte: first, last_byte: last};
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // lead byte for a character of len bytes, payload bits random
  function automatic logic [7:0] lead_for(int unsigned len);
    logic [7:0] mask;
    if (len == 1) return 8'($urandom) & 8'h7F;
    mask = 8'hFF >> len;
    return ~mask | (8'($urandom) & (mask >> 1));
  endfunction

  // a random string: mostly well-formed characters, now and then a fault
  task automatic send_string();
    logic [7:0]  seq[$];
    int unsigned nchars;
    int unsigned len;
    int unsigned i;
    int unsigned k;
    int unsigned pos;
    logic        first;
    nchars = $urandom_range(1, 8);
    for (i = 0; i < nchars; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = 1;
        4, 5:       len = 2;
        6:          len = 3;
        7:          len = 4;
        8:          len = $urandom_range(5, 7);
        default:    len = 8;
      endcase
      seq.push_back(lead_for(len));
      for (k = 1; k < len; k++) seq.push_back({2'b10, 6'($urandom)});
    end
    if ($urandom_range(0, 99) < 25) begin
      pos = $urandom_range(0, seq.size() - 1);
      case ($urandom_range(0, 3))
        0: seq[pos] = 8'($urandom);                         // random byte in place
        1: seq.insert(pos, {2'b10, 6'($urandom)});          // stray continuation
        2: if (seq.size() > 1) void'(seq.pop_back());        // cut short
        default: begin                                      // pure noise
          seq.delete();
          repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom));
        end
      endcase
    end
    // now and then the string carries on from the last one's count
    first = ($urandom_range(0, 9) != 0);
    calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < seq.size(); i++)
      send_beat(seq[i], first && i == 0, i == seq.size() - 1);
  endtask

  initial begin
    rst = 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    calm = 1'b0;
    tail = 1'b0;
    beats_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: ascii extremes, two/three/four byte chars, stray continuation
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h7F, 1'b0, 1'b0);
    send_beat(8'hC2, 1'b0, 1'b0);
    send_beat(8'hA9, 1'b0, 1'b0);
    send_beat(8'hE2, 1'b0, 1'b0);
    send_beat(8'h82, 1'b0, 1'b0);
    send_beat(8'hAC, 1'b0, 1'b0);
    send_beat(8'hF0, 1'b0, 1'b0);
    send_beat(8'h9F, 1'b0, 1'b0);
    send_beat(8'h98, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0);
    send_beat(8'h41, 1'b0, 1'b1);
    // bad continuation swallowed, then a string ending inside a sequence
    send_beat(8'hE2, 1'b1, 1'b0);
    send_beat(8'h41, 1'b0, 1'b0);
    send_beat(8'hC3, 1'b0, 1'b1);
    // all-ones lead owes seven continuations, value overflows 32 bits
    send_beat(8'hFF, 1'b1, 1'b0);
    repeat (6) send_beat(8'hBF, 1'b0, 1'b0);
    send_beat(8'hBF, 1'b0, 1'b1);

    // random strings, the last stretch without any idling
    while (beats_sent < 740) begin
      tail = (beats_sent > 640);
      send_string();
    end
    in_valid <= 1'b0;

    wait (awaited_count == 0);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/utf8d_pkg.sv
rtl/utf8d_decode.sv
rtl/utf8_stream_decoder_core.sv
tb/utf8_stream_decoder_checker.sv
tb/utf8_stream_decoder_core_tb.sv
